// ----- hw/rtl/pee_pkg.sv -----
`default_nettype none

package pee_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_OK    = 3'd0,
        STAT_UNDER = 3'd1,
        STAT_OVER  = 3'd2,
        STAT_DIVZ  = 3'd3,
        STAT_BAD   = 3'd4,
        STAT_LEFT  = 3'd5
    } pee_status_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_ITER,
        ST_FINISH
    } pee_state_t;

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Controller to datapath
    typedef struct packed {
        logic        latch_in;
        logic        push;
        logic        rd_req;
        logic        wr_alu;
        logic        mdu_start;
        logic        wr_mdu;
        logic        set_err;
        pee_status_t err_code;
        logic        finish_end;
    } pee_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic err_active;
        logic is_digit;
        logic is_op;
        logic is_mul_div;
        logic is_div;
        logic stack_full;
        logic lt_two;
        logic rhs_zero;
        logic mdu_done;
        logic end_flag;
    } pee_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pee_ram.sv -----
`default_nettype none

module pee_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pee_mdu.sv -----
`default_nettype none

// Shared iterative multiply / signed divide, one bit per cycle
module pee_mdu #(
    parameter int W = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic         is_div,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic              done,
    output logic      [W-1:0] result
);

    localparam int CNTW = $clog2(W + 1);

    logic [W-1:0]    acc_reg, acc_next;
    logic [W-1:0]    x_reg, x_next;
    logic [W-1:0]    y_reg, y_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic            div_reg, div_next;
    logic            neg_reg, neg_next;

    logic [W-1:0]    a_mag, b_mag;
    logic [W:0]      rem_shift;
    logic            fits;

    assign a_mag = a[W-1] ? (-a) : a;
    assign b_mag = b[W-1] ? (-b) : b;

    // Restoring divide step: bring down next dividend bit
    assign rem_shift = {acc_reg, x_reg[W-1]};
    assign fits      = (rem_shift >= {1'b0, y_reg});

    always_comb
    begin
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            div_next  = is_div;
            neg_next  = a[W-1] ^ b[W-1];
            acc_next  = '0;
            x_next    = is_div ? a_mag : a;
            y_next    = is_div ? b_mag : b;
            cnt_next  = CNTW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                if (fits)
                begin
                    acc_next = W'(rem_shift - {1'b0, y_reg});
                end
                else
                begin
                    acc_next = rem_shift[W-1:0];
                end
                x_next = {x_reg[W-2:0], fits};
            end
            else
            begin
                // shift-add, product kept modulo 2^W
                if (y_reg[0])
                begin
                    acc_next = acc_reg + x_reg;
                end
                x_next = {x_reg[W-2:0], 1'b0};
                y_next = {1'b0, y_reg[W-1:1]};
            end
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    assign done   = done_reg;
    assign result = div_reg ? (neg_reg ? (-x_reg) : x_reg) : acc_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pee_datapath.sv -----
`default_nettype none

module pee_datapath
    import pee_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  token,
    input  wire logic        end_of_expr,
    input  wire pee_cmd_t    cmd,
    output pee_stat_t        stat,
    output logic signed [15:0] result_value,
    output logic [2:0]       status
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int W  = VALUE_WIDTH;

    logic [7:0]        tok_reg;
    logic              end_reg;
    logic [W-1:0]      tos_reg, tos_next;
    logic [CW-1:0]     count_reg, count_next;
    pee_status_t       sticky_reg, sticky_next;
    logic [15:0]       result_reg;
    pee_status_t       status_reg;

    logic [CW-1:0]     count_m1, count_m2;
    logic              ram_wr_en;
    logic [W-1:0]      ram_rdata;
    logic              mdu_done;
    logic [W-1:0]      mdu_result;
    logic              is_add;
    pee_status_t       fin_status;
    logic [W+15:0]     tos_ext;

    assign count_m1 = count_reg - CW'(1);
    assign count_m2 = count_reg - CW'(2);

    // Token decode and status flags to the controller
    always_comb
    begin
        stat.err_active = (sticky_reg != STAT_OK);
        stat.is_digit   = (tok_reg >= CH_ZERO) && (tok_reg <= CH_NINE);
        stat.is_op      = (tok_reg == CH_PLUS) || (tok_reg == CH_MINUS)
                       || (tok_reg == CH_STAR) || (tok_reg == CH_SLASH);
        stat.is_mul_div = (tok_reg == CH_STAR) || (tok_reg == CH_SLASH);
        stat.is_div     = (tok_reg == CH_SLASH);
        stat.stack_full = (count_reg == CW'(STACK_DEPTH));
        stat.lt_two     = (count_reg < CW'(2));
        stat.rhs_zero   = (tos_reg == '0);
        stat.mdu_done   = mdu_done;
        stat.end_flag   = end_reg;
    end

    assign is_add = (tok_reg == CH_PLUS);

    // Entries below the top of stack live in RAM; the top sits in tos_reg
    assign ram_wr_en = cmd.push && (count_reg != '0);

    pee_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_m1[AW-1:0]),
        .wr_data (tos_reg),
        .rd_en   (cmd.rd_req),
        .rd_addr (count_m2[AW-1:0]),
        .rd_data (ram_rdata)
    );

    pee_mdu #(
        .W (W)
    ) u_mdu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mdu_start),
        .is_div (stat.is_div),
        .a      (ram_rdata),
        .b      (tos_reg),
        .done   (mdu_done),
        .result (mdu_result)
    );

    // End-of-expression status and value
    always_comb
    begin
        if (sticky_reg != STAT_OK)
        begin
            fin_status = sticky_reg;
        end
        else if (count_reg == '0)
        begin
            fin_status = STAT_UNDER;
        end
        else if (count_reg > CW'(1))
        begin
            fin_status = STAT_LEFT;
        end
        else
        begin
            fin_status = STAT_OK;
        end
    end

    assign tos_ext = {{16{tos_reg[W-1]}}, tos_reg};

    // Stack pointer, top of stack and sticky status
    always_comb
    begin
        tos_next    = tos_reg;
        count_next  = count_reg;
        sticky_next = sticky_reg;
        if (cmd.push)
        begin
            tos_next   = W'(tok_reg[3:0]);
            count_next = count_reg + CW'(1);
        end
        if (cmd.wr_alu)
        begin
            tos_next   = is_add ? (ram_rdata + tos_reg) : (ram_rdata - tos_reg);
            count_next = count_m1;
        end
        if (cmd.wr_mdu)
        begin
            tos_next   = mdu_result;
            count_next = count_m1;
        end
        if (cmd.set_err)
        begin
            sticky_next = cmd.err_code;
        end
        if (cmd.finish_end)
        begin
            count_next  = '0;
            sticky_next = STAT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sticky_reg <= STAT_OK;
        end
        else
        begin
            count_reg  <= count_next;
            sticky_reg <= sticky_next;
        end
    end

    // Input beat, top of stack and output beat payload
    always_ff @(posedge clk)
    begin
        tos_reg <= tos_next;
        if (cmd.latch_in)
        begin
            tok_reg <= token;
            end_reg <= end_of_expr;
        end
        if (cmd.finish_end)
        begin
            status_reg <= fin_status;
            result_reg <= (fin_status == STAT_OK) ? tos_ext[15:0] : 16'd0;
        end
    end

    assign result_value = result_reg;
    assign status       = status_reg;

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (count_reg < CW'(STACK_DEPTH)))
        else $error("push into full stack");

    a_pop_two: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_alu || cmd.wr_mdu) |-> (count_reg >= CW'(2)))
        else $error("operator result written with fewer than two operands");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish_end |=> ((count_reg == '0) && (sticky_reg == STAT_OK)))
        else $error("stack not cleared after end of expression");

    a_err_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        ((sticky_reg != STAT_OK) && !cmd.finish_end) |=> $stable(count_reg))
        else $error("stack changed after an error");

endmodule

`default_nettype wire

// ----- hw/rtl/pee_ctrl.sv -----
`default_nettype none

module pee_ctrl
    import pee_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  wire logic      out_stall,
    input  wire pee_stat_t stat,
    output pee_cmd_t       cmd
);

    pee_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    // Output register can take a new beat
    assign out_free = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (!stat.err_active && stat.is_op && !stat.lt_two)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ:
            begin
                if (stat.is_mul_div && !(stat.is_div && stat.rhs_zero))
                begin
                    state_next = ST_ITER;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_ITER:
            begin
                if (stat.mdu_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!stat.end_flag || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        cmd.err_code = STAT_OK;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.latch_in = in_valid;
            end
            ST_DECODE:
            begin
                if (!stat.err_active)
                begin
                    if (stat.is_digit)
                    begin
                        if (stat.stack_full)
                        begin
                            cmd.set_err  = 1'b1;
                            cmd.err_code = STAT_OVER;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                        end
                    end
                    else if (stat.is_op)
                    begin
                        if (stat.lt_two)
                        begin
                            cmd.set_err  = 1'b1;
                            cmd.err_code = STAT_UNDER;
                        end
                        else
                        begin
                            cmd.rd_req = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = STAT_BAD;
                    end
                end
            end
            ST_READ:
            begin
                if (!stat.is_mul_div)
                begin
                    cmd.wr_alu = 1'b1;
                end
                else if (stat.is_div && stat.rhs_zero)
                begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = STAT_DIVZ;
                end
                else
                begin
                    cmd.mdu_start = 1'b1;
                end
            end
            ST_ITER:
            begin
                cmd.wr_mdu = stat.mdu_done;
            end
            ST_FINISH:
            begin
                cmd.finish_end = stat.end_flag && out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign out_valid_next = cmd.finish_end || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/postfix_expression_evaluator_unit.sv -----
`default_nettype none

// Channel  Direction  Handshake            Beat fields
// input    in         in_valid / in_stall  token[7:0], end_of_expr
// output   out        out_valid / out_stall result_value[15:0], status[2:0]
//
// One character at a time: a digit is pushed, + and - go through the adder,
// and * and / through the bit-serial multiply/divide unit.
// Operators read the left operand from the stack RAM (one read port).
// Reset clears the stack count, the sticky status and the output valid.
// A result waiting under out_stall holds an end-marked character in its
// final cycle; other characters keep flowing.
module postfix_expression_evaluator_unit
    import pee_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         token,
    input  wire logic               end_of_expr,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      result_value,
    output logic [2:0]              status
);

    pee_cmd_t  cmd;
    pee_stat_t stat;

    pee_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    pee_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .token        (token),
        .end_of_expr  (end_of_expr),
        .cmd          (cmd),
        .stat         (stat),
        .result_value (result_value),
        .status       (status)
    );

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import pee_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int STACK_DEPTH     = 16;
    localparam int VALUE_WIDTH     = 16;
    localparam int RESET_CYCLES    = 6;
    localparam int RANDOM_BEATS    = 1400;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 2 * VALUE_WIDTH + 20;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int IDLE_PCT        = 16;

    typedef logic [7:0] char_q_t[$];

    typedef struct {
        logic signed [15:0] value;
        pee_status_t        stat;
    } expr_result_t;

    // DUT ports, inputs known from time zero
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         token = 8'h00;
    logic               end_of_expr = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] result_value;
    logic [2:0]         status;

    // predictor state
    logic [15:0]        operand_mem [STACK_DEPTH];
    int                 operand_cnt = 0;
    pee_status_t        expr_status = STAT_OK;
    expr_result_t       pending_results[$];

    // test control
    bit                 idle_in = 1'b1;
    bit                 idle_out = 1'b1;
    int unsigned        hold_left = 0;
    int unsigned        live_beats = 0;
    int unsigned        error_count = 0;
    int unsigned        cycle_count = 0;
    expr_result_t       head_result;

    logic [7:0]         op_chars [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

    postfix_expression_evaluator_unit #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .token        (token),
        .end_of_expr  (end_of_expr),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .status       (status)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Evaluate one accepted character; queue the result on an end-marked beat
    function automatic void predict_beat(input logic [7:0] tok, input logic last);
        logic [15:0]  rhs;
        logic [15:0]  lhs;
        int           quotient;
        expr_result_t res;
        live_beats++;
        if (expr_status == STAT_OK) begin
            case (tok)
                CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH:
                begin
                    if (operand_cnt < 2)
                        expr_status = STAT_UNDER;
                    else
                    begin
                        rhs = operand_mem[operand_cnt - 1];
                        lhs = operand_mem[operand_cnt - 2];
                        if (tok == CH_SLASH && rhs == 16'd0)
                            expr_status = STAT_DIVZ;
                        else
                        begin
                            case (tok)
                                CH_PLUS:  lhs = lhs + rhs;
                                CH_MINUS: lhs = lhs - rhs;
                                CH_STAR:  lhs = lhs * rhs;
                                default:
                                begin
                                    // 32-bit divide so min / -1 wraps on truncation
                                    quotient = $signed(lhs) / $signed(rhs);
                                    lhs = quotient[15:0];
                                end
                            endcase
                            operand_cnt--;
                            operand_mem[operand_cnt - 1] = lhs;
                        end
                    end
                end
                default:
                begin
                    if (tok >= CH_ZERO && tok <= CH_NINE)
                    begin
                        if (operand_cnt >= STACK_DEPTH)
                            expr_status = STAT_OVER;
                        else
                        begin
                            operand_mem[operand_cnt] = {8'h00, tok - CH_ZERO};
                            operand_cnt++;
                        end
                    end
                    else
                        expr_status = STAT_BAD;
                end
            endcase
        end
        if (last) begin
            res.stat = expr_status;
            if (res.stat == STAT_OK && operand_cnt == 0)
                res.stat = STAT_UNDER;
            else if (res.stat == STAT_OK && operand_cnt > 1)
                res.stat = STAT_LEFT;
            res.value = (res.stat == STAT_OK) ? operand_mem[0] : 16'sd0;
            pending_results.push_back(res);
            operand_cnt = 0;
            expr_status = STAT_OK;
        end
    endfunction

    // Drive one beat and hold it until the block takes it
    task automatic send_beat(input logic [7:0] tok, input logic last);
        while (idle_in && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        token       <= tok;
        end_of_expr <= last;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        predict_beat(tok, last);
    endtask

    task automatic send_chars(input char_q_t seq);
        foreach (seq[i])
            send_beat(seq[i], i == seq.size() - 1);
    endtask

    task automatic send_text(input string s);
        char_q_t seq;
        for (int i = 0; i < s.len(); i++)
            seq.push_back(s[i]);
        send_chars(seq);
    endtask

    // Sender goes quiet until every queued result has come back
    task automatic wait_drained(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Well-formed postfix expression, stack depth capped at max_depth
    function automatic char_q_t build_expr(input int max_depth, input int target);
        char_q_t seq;
        int      depth;
        depth = 0;
        forever begin
            if (depth < 2 || (depth < max_depth && seq.size() < target
                              && $urandom_range(0, 1) == 1)) begin
                seq.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                depth++;
            end
            else begin
                seq.push_back(op_chars[$urandom_range(0, 3)]);
                depth--;
            end
            if (depth == 1 && seq.size() >= target)
                break;
        end
        return seq;
    endfunction

    // Short expressions: every operator, extremes of the token, error cases
    task automatic test_directed();
        send_text("7");
        send_text("35-");
        send_text("78*");
        send_text("07-2/");     // -3.5 truncates to -3
        send_text("50/");       // divide by zero
        send_text("+");         // operator on empty stack
        send_text("12");        // leftover operands
        send_beat(8'h00, 1'b1); // bad character, all bits low
        send_beat(8'hFF, 1'b1); // bad character, all bits high
        send_text("10/9*");     // error stays until end mark
        send_text("1a");
    endtask

    // Wrapping products and the most negative value over -1
    task automatic test_value_extremes();
        send_text("99*9*9*9*");
        send_text("88*8*8*8*1-");
        send_text("88*8*8*8*01-/");
    endtask

    // Full stack reduced to one value, then one push too many
    task automatic test_stack_limits();
        char_q_t seq;
        for (int i = 0; i < STACK_DEPTH; i++)
            seq.push_back(CH_ZERO + 8'd1);
        for (int i = 1; i < STACK_DEPTH; i++)
            seq.push_back(CH_PLUS);
        send_chars(seq);
        seq.delete();
        for (int i = 0; i <= STACK_DEPTH; i++)
            seq.push_back(CH_NINE);
        send_chars(seq);
    endtask

    // Receiver holds off for a long stretch while expressions keep coming
    task automatic test_backpressure();
        hold_left <= HOLD_OFF_CYCLES;
        repeat (12)
            send_chars(build_expr(4, $urandom_range(1, 7)));
        wait_drained(0);
    endtask

    // Mostly well-formed expressions, some broken ones and raw noise
    task automatic test_random_exprs();
        char_q_t     seq;
        int unsigned start;
        int unsigned progress;
        int unsigned next_pause;
        int          roll;
        start = live_beats;
        next_pause = 400;
        while (live_beats - start < RANDOM_BEATS) begin
            progress = live_beats - start;
            // quiet stretch: no idling on either side
            idle_in = !(progress >= 600 && progress < 900);
            idle_out <= idle_in;
            if (progress >= next_pause) begin
                wait_drained(0);
                next_pause += 400;
            end
            roll = $urandom_range(0, 99);
            if (roll < 10)
                seq = build_expr($urandom_range(12, STACK_DEPTH + 1), $urandom_range(10, 40));
            else
                seq = build_expr($urandom_range(2, 6), $urandom_range(1, 20));
            if (roll >= 80 && roll < 92) begin
                case ($urandom_range(0, 3))
                    0: seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom_range(0, 255));
                    1: if (seq.size() > 1) void'(seq.pop_back());
                    2: seq.push_front(op_chars[$urandom_range(0, 3)]);
                    default: seq.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                endcase
            end
            else if (roll >= 92) begin
                seq.delete();
                repeat ($urandom_range(1, 6))
                    seq.push_back(8'($urandom_range(0, 255)));
            end
            send_chars(seq);
        end
        idle_in = 1'b1;
        idle_out <= 1'b1;
    endtask

    // Output stall: long hold-off when requested, else random while idle_out is set
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= idle_out && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Compare each result beat against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected: value %0d status %0d",
                         $time, result_value, status);
                error_count++;
            end
            else begin
                head_result = pending_results.pop_front();
                if (result_value !== head_result.value) begin
                    $display("%0t: result_value expected %0d got %0d",
                             $time, head_result.value, result_value);
                    error_count++;
                end
                if (status !== head_result.stat) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, head_result.stat, status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_value_extremes();
        test_stack_limits();
        test_backpressure();
        test_random_exprs();
        wait_drained(SETTLE_CYCLES);
        if (error_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
